@@ design/slip_receive_decoder_fifo_unit_defines.svh @@
// Assertion macros shared by the SLIP receive decoder FIFO design files.
`ifndef SLIP_RECEIVE_DECODER_FIFO_UNIT_DEFINES_SVH
`define SLIP_RECEIVE_DECODER_FIFO_UNIT_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define SRDF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SRDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/srdf_pkg.sv @@
// Types, codes and the SLIP decode function of the receive decoder FIFO.
package srdf_pkg;

    localparam int FIFO_DEPTH_DEF = 256;

    localparam logic OP_LINE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0] CODE_END     = 8'hC0;
    localparam logic [7:0] CODE_ESC     = 8'hDB;
    localparam logic [7:0] CODE_ESC_END = 8'hDC;
    localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

    typedef struct packed {
        logic       opcode;
        logic [7:0] line_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic       byte_stored;
        logic       byte_dropped;
        logic [8:0] fill_level;
    } t_out;

    typedef struct packed {
        logic       have;
        logic [7:0] value;
        logic       esc;
    } t_dec;

    // Decode one line byte under the current escape flag.
    function automatic t_dec slip_decode(input logic [7:0] b, input logic esc);
        t_dec d;
        d.have  = 1'b1;
        d.value = b;
        d.esc   = 1'b0;
        case (b)
            CODE_END: begin
                d.have = 1'b0;
                d.esc  = esc;
            end
            CODE_ESC: begin
                d.have = 1'b0;
                d.esc  = 1'b1;
            end
            CODE_ESC_END: begin
                if (esc) d.value = CODE_END;
            end
            CODE_ESC_ESC: begin
                if (esc) d.value = CODE_ESC;
            end
            default: begin
                d.value = b;
            end
        endcase
        return d;
    endfunction

endpackage

@@ design/srdf_out_skid.sv @@
// Output skid register that parks a result while the receiver stalls.
module srdf_out_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s1_valid,
    input  srdf_pkg::t_out i_s1,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_ready,
    output srdf_pkg::t_out o_out
);
    import srdf_pkg::*;

    logic r_skid_valid;
    t_out r_skid;
    logic w_load;

    // Refill from the stage when draining, or catch the stage when stalled.
    assign w_load = r_skid_valid ? i_ready : (i_s1_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) r_skid_valid <= i_s1_valid;
        end else if (i_s1_valid && !i_ready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_skid <= i_s1;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_skid_valid || i_s1_valid;
    assign o_out   = r_skid_valid ? r_skid : i_s1;

endmodule

@@ design/slip_receive_decoder_fifo_unit.sv @@
// Top level of the SLIP receive decoder with a ring FIFO of decoded bytes.
//
// Input channel (i_valid / o_ready, payload i_in): each transfer is one item.
//   opcode OP_LINE hands in a raw line byte; it is SLIP-decoded under a
//   one-bit escape flag and any decoded byte is pushed into the FIFO, or
//   dropped and flagged when the FIFO is full.
//   opcode OP_READ pops the oldest decoded byte, or reports empty.
// Output channel (o_valid / i_ready, payload o_out): exactly one result
//   transfer per input item, in order.
// Result path: a result is registered in the result stage, which waits on
//   the synchronous read port of the byte store.
// Throughput: one item per cycle while the receiver takes results. The
//   FIFO counters and the store are read-modify-written at accept time,
//   so back-to-back items of any kind never wait on one another.
// Stall: when the receiver stalls, the pending result parks in a skid
//   register and one more item is still accepted; o_ready then drops until
//   the parked results drain.
// Reset (synchronous, active low): FIFO empty, indices zero, escape flag
//   clear, no result pending. The store needs no clearing: the fill count
//   guards every pop, so an unwritten entry is never read.
module slip_receive_decoder_fifo_unit #(
    parameter int FIFO_DEPTH = srdf_pkg::FIFO_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  srdf_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_ready,
    output srdf_pkg::t_out o_out
);
    import srdf_pkg::*;

    `include "slip_receive_decoder_fifo_unit_defines.svh"

    localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

    // Decoded byte store, one write and one registered read per cycle.
    logic [7:0] r_mem [FIFO_DEPTH];
    logic [7:0] r_mem_q;

    // FIFO and decoder state.
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_esc, n_esc;

    // Result stage that waits on the store's read data.
    logic       r_s1_valid;
    logic       r_s1_rvalid;
    logic       r_s1_stored;
    logic       r_s1_dropped;
    logic [8:0] r_s1_fill;
    t_out       w_s1_out;

    logic w_skid_full;
    logic w_accept;
    logic w_is_read;
    t_dec w_dec;
    logic w_full;
    logic w_empty;
    logic w_push;
    logic w_drop;
    logic w_pop;

    assign o_ready   = !w_skid_full;
    assign w_accept  = i_valid && o_ready;
    assign w_is_read = (i_in.opcode == OP_READ);
    assign w_dec     = slip_decode(i_in.line_byte, r_esc);
    assign w_full    = (r_count == FULL_CNT);
    assign w_empty   = (r_count == '0);

    // Push a decoded byte, drop it when full, pop only when something is held.
    assign w_push = w_accept && !w_is_read && w_dec.have && !w_full;
    assign w_drop = w_accept && !w_is_read && w_dec.have && w_full;
    assign w_pop  = w_accept && w_is_read && !w_empty;

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        n_esc    = r_esc;
        if (w_accept && !w_is_read) n_esc = w_dec.esc;
        if (w_push) begin
            n_wr_idx = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
            n_count  = r_count + 1'b1;
        end
        if (w_pop) begin
            n_rd_idx = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
            n_count  = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
            r_esc    <= 1'b0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
            r_esc    <= n_esc;
        end
    end

    // Write the pushed byte; read the popped one. Push and pop never share a
    // cycle, and a pop always targets an entry written in an earlier cycle.
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_idx] <= w_dec.value;
        if (w_pop)  r_mem_q <= r_mem[r_rd_idx];
    end

    // Advance the stage on accept; while the skid register is full, hold it,
    // or retire it into the skid register once the receiver takes a result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!w_skid_full) begin
            r_s1_valid <= w_accept;
        end else if (i_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_rvalid  <= w_pop;
            r_s1_stored  <= w_push;
            r_s1_dropped <= w_drop;
            r_s1_fill    <= 9'(n_count);
        end
    end

    always_comb begin
        w_s1_out.read_data    = r_s1_rvalid ? r_mem_q : 8'h00;
        w_s1_out.read_valid   = r_s1_rvalid;
        w_s1_out.byte_stored  = r_s1_stored;
        w_s1_out.byte_dropped = r_s1_dropped;
        w_s1_out.fill_level   = r_s1_fill;
    end

    srdf_out_skid u_out_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (r_s1_valid),
        .i_s1       (w_s1_out),
        .o_full     (w_skid_full),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out)
    );

    `SRDF_ASSERT_ALWAYS(a_count_bound, r_count <= FULL_CNT, "fill count exceeds depth")
    `SRDF_ASSERT_ALWAYS(a_empty_idx, (r_count != '0) || (r_wr_idx == r_rd_idx),
        "empty FIFO with split indices")
    `SRDF_ASSERT_NEXT(a_push_count, w_push, r_count == $past(r_count) + 1'b1,
        "push did not raise count")
    `SRDF_ASSERT_NEXT(a_drop_hold, w_drop, (r_count == FULL_CNT) && $stable(r_wr_idx),
        "drop moved FIFO state")
    `SRDF_ASSERT_ALWAYS(a_s1_one_kind,
        !r_s1_valid || $onehot0({r_s1_rvalid, r_s1_stored, r_s1_dropped}),
        "result flags conflict")

endmodule
